FILE: sv/assert_macros.svh
// Assertion macros for the six-bit stream parser checkers.
// Depends on nothing; included by the files that hold assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while rst is high.
`define ISP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is checked during reset as well.
`define ISP_ASSERT_ALWAYS(label, clk, prop, msg) \
   `ISP_ASSERT(label, clk, 1'b0, prop, msg)

`endif

FILE: sv/isp_pkg.sv
// Shared types and constants of the six-bit stream parser.
// No dependencies; imported by every module of the block.
package isp_pkg;

   localparam int unsigned MAX_ROWS     = 65536;
   localparam int unsigned MAX_COLS     = 65536;
   localparam int unsigned HEADER_BYTES = 16;
   localparam int          HDR_CNT_W    = $clog2(HEADER_BYTES);

   localparam logic [31:0] CSUM_LIMIT_RST = 32'd100000;
   localparam logic [16:0] STATS_ROWS_RST = 17'd1000;

   localparam logic [5:0]  SIGN_FLIP = 6'h20;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SCALES,
      PH_PAYLOAD,
      PH_SURPLUS,
      PH_ERROR
   } phase_type;

   localparam logic [2:0] KIND_VALUE    = 3'd0;
   localparam logic [2:0] KIND_SCALE    = 3'd1;
   localparam logic [2:0] KIND_STATUS   = 3'd2;
   localparam logic [2:0] KIND_CHECKSUM = 3'd3;
   localparam logic [2:0] KIND_MIN      = 3'd4;
   localparam logic [2:0] KIND_MAX      = 3'd5;
   localparam logic [2:0] KIND_MISSING  = 3'd6;
   localparam logic [2:0] KIND_EXTRA    = 3'd7;

   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_BAD_MAGIC     = 3'd1;
   localparam logic [2:0] ST_OVERSIZE      = 3'd2;
   localparam logic [2:0] ST_SHORT_HEADER  = 3'd3;
   localparam logic [2:0] ST_SHORT_SCALES  = 3'd4;
   localparam logic [2:0] ST_SHORT_PAYLOAD = 3'd5;

   localparam logic [1:0] CSR_OVR_ROWS   = 2'd0;
   localparam logic [1:0] CSR_OVR_COLS   = 2'd1;
   localparam logic [1:0] CSR_CSUM_LIMIT = 2'd2;
   localparam logic [1:0] CSR_STATS_ROWS = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } isp_in_type;

   typedef struct packed {
      logic        val_a;
      logic        val_b;
      logic        scale;
      logic        summary;
      logic [5:0]  q_a;
      logic [5:0]  q_b;
      logic [15:0] row;
      logic [15:0] col_a;
      logic [15:0] col_b;
      logic [31:0] scale_word;
      logic [2:0]  status;
      logic [63:0] checksum;
      logic        have;
      logic [5:0]  min_q;
      logic [5:0]  max_q;
      logic        missing_en;
      logic [16:0] rows;
      logic [16:0] cols;
      logic [31:0] pbytes;
      logic [31:0] surplus;
   } isp_bundle_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0:    m = 8'h50;
         2'd1:    m = 8'h52;
         2'd2:    m = 8'h54;
         default: m = 8'h36;
      endcase
      return m;
   endfunction

endpackage

FILE: sv/isp_in_stage.sv
// Input skid stage of the six-bit stream parser: two-entry buffer, registered ready.
// Depends on isp_pkg.
module isp_in_stage
   import isp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  isp_in_type req_item,
   output logic       item_valid,
   output isp_in_type item,
   input  logic       item_take
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   isp_in_type main_ff, main_in;
   isp_in_type skid_ff, skid_in;
   logic       accept;

   assign req_ready  = !skid_valid_ff;
   assign accept     = req_valid && !skid_valid_ff;
   assign item_valid = main_valid_ff;
   assign item       = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (item_take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            main_in = req_item;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (main_valid_ff) begin
            skid_in       = req_item;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = req_item;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: sv/isp_parse.sv
// Parser core: header check, scale assembly, six-bit unpack, checksum and statistics.
// Depends on isp_pkg; produces one result bundle per byte for isp_emit.
module isp_parse
   import isp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [31:0]    csr_wdata,
   input  logic           item_take,
   input  isp_in_type     item,
   output isp_bundle_type bundle
);

   typedef struct packed {
      logic [HDR_CNT_W-1:0] hdr_cnt;
      logic [31:0]          rows;
      logic [31:0]          cols;
      logic [23:0]          scale;
      logic [1:0]           scale_pos;
      logic [16:0]          row;
      logic [16:0]          col;
      logic [1:0]           grp;
      logic [3:0]           carry;
      logic [63:0]          csum;
      logic [32:0]          seen;
      logic [7:0]           smin;
      logic [7:0]           smax;
      logic [31:0]          pbytes;
      logic [31:0]          surplus;
      logic [2:0]           status;
   } parse_state_type;

   localparam parse_state_type STATE_RST = '{
      hdr_cnt: '0, rows: '0, cols: '0, scale: '0, scale_pos: '0, row: '0, col: '0,
      grp: '0, carry: '0, csum: '0, seen: '0, smin: 8'h7F, smax: 8'h81,
      pbytes: '0, surplus: '0, status: ST_OK};

   phase_type       phase_ff, phase_mid, phase_in;
   parse_state_type st_ff, st_mid, st_in;

   logic [16:0] ovr_rows_ff, ovr_cols_ff, stats_rows_ff;
   logic [31:0] csum_lim_ff;

   logic [7:0]           b;
   logic                 fin;
   logic [HDR_CNT_W-1:0] h;
   logic                 bad_magic, hdr_last, oversize;
   logic [31:0]          cols_full, rows_use, cols_use;
   logic [16:0]          row_inc, col_a, col_b, col4;
   logic                 rows_done, row_wrap;
   logic [5:0]           code_a, code_b, q_a, q_b;
   logic                 take_a, take_b, fold_a, fold_b, in_stats, have;
   logic [10:0]          a31;
   logic [63:0]          csum_one, csum_two;
   logic signed [7:0]    v_a, v_b, min_t, max_t;

   assign b   = item.data_byte;
   assign fin = item.final_byte;
   assign h   = st_ff.hdr_cnt;

   assign bad_magic = (h < HDR_CNT_W'(4)) && (b != magic_byte(h[1:0]));
   assign hdr_last  = (h == HDR_CNT_W'(HEADER_BYTES - 1));
   assign cols_full = {b, st_ff.cols[23:0]};
   assign rows_use  = (ovr_rows_ff != '0) ? {15'b0, ovr_rows_ff} : st_ff.rows;
   assign cols_use  = (ovr_cols_ff != '0) ? {15'b0, ovr_cols_ff} : cols_full;
   assign oversize  = (rows_use > 32'(MAX_ROWS)) || (cols_use > 32'(MAX_COLS));

   assign row_inc   = st_ff.row + 17'd1;
   assign rows_done = {15'b0, row_inc} >= st_ff.rows;
   assign col4      = st_ff.col + 17'd4;
   assign row_wrap  = {15'b0, col4} >= st_ff.cols;
   assign col_a     = st_ff.col + {15'b0, st_ff.grp};
   assign col_b     = st_ff.col + 17'd3;
   assign take_a    = {15'b0, col_a} < st_ff.cols;
   assign take_b    = (st_ff.grp == 2'd2) && ({15'b0, col_b} < st_ff.cols);

   always_comb begin
      case (st_ff.grp)
         2'd0:    code_a = b[5:0];
         2'd1:    code_a = {b[3:0], st_ff.carry[1:0]};
         default: code_a = {b[1:0], st_ff.carry};
      endcase
   end

   assign code_b = b[7:2];
   assign q_a    = code_a ^ SIGN_FLIP;
   assign q_b    = code_b ^ SIGN_FLIP;
   assign v_a    = $signed({{2{q_a[5]}}, q_a});
   assign v_b    = $signed({{2{q_b[5]}}, q_b});

   assign fold_a   = take_a && (st_ff.seen < {1'b0, csum_lim_ff});
   assign fold_b   = take_b && ((st_ff.seen + 33'd1) < {1'b0, csum_lim_ff});
   assign a31      = {code_a, 5'b0} - {5'b0, code_a};
   assign csum_one = (st_ff.csum << 5) - st_ff.csum + {58'b0, code_a};
   assign csum_two = (st_ff.csum << 10) - (st_ff.csum << 6) + st_ff.csum
                     + {53'b0, a31} + {58'b0, code_b};
   assign in_stats = st_ff.row < stats_rows_ff;

   // next phase
   always_comb begin
      phase_mid = phase_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (bad_magic) begin
               phase_mid = PH_ERROR;
            end else if (hdr_last) begin
               if (oversize) begin
                  phase_mid = PH_ERROR;
               end else if (rows_use == '0) begin
                  phase_mid = PH_SURPLUS;
               end else begin
                  phase_mid = PH_SCALES;
               end
            end
         end
         PH_SCALES: begin
            if ((st_ff.scale_pos == 2'd3) && rows_done) begin
               phase_mid = (st_ff.cols == '0) ? PH_SURPLUS : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if ((st_ff.grp == 2'd2) && row_wrap && rows_done) begin
               phase_mid = PH_SURPLUS;
            end
         end
         default: phase_mid = phase_ff;
      endcase
      if (!item_take) begin
         phase_in = phase_ff;
      end else if (fin) begin
         phase_in = PH_HEADER;
      end else begin
         phase_in = phase_mid;
      end
   end

   // datapath and result bundle
   always_comb begin
      st_mid = st_ff;
      bundle = '0;
      min_t  = $signed(st_ff.smin);
      max_t  = $signed(st_ff.smax);
      have   = 1'b0;
      case (phase_ff)
         PH_HEADER: begin
            if (bad_magic) begin
               st_mid.status = ST_BAD_MAGIC;
            end else begin
               st_mid.hdr_cnt = h + HDR_CNT_W'(1);
               if (h[3:2] == 2'd2) begin
                  st_mid.rows[{h[1:0], 3'b000} +: 8] = b;
               end else if (h[3:2] == 2'd3) begin
                  st_mid.cols[{h[1:0], 3'b000} +: 8] = b;
               end
               if (hdr_last) begin
                  st_mid.rows = rows_use;
                  st_mid.cols = cols_use;
                  if (oversize) begin
                     st_mid.status = ST_OVERSIZE;
                  end else begin
                     st_mid.row       = '0;
                     st_mid.scale_pos = '0;
                     st_mid.scale     = '0;
                  end
               end
            end
         end
         PH_SCALES: begin
            if (st_ff.scale_pos == 2'd3) begin
               bundle.scale      = 1'b1;
               bundle.scale_word = {b, st_ff.scale};
               bundle.row        = st_ff.row[15:0];
               st_mid.scale      = '0;
               st_mid.scale_pos  = '0;
               st_mid.row        = row_inc;
               if (rows_done) begin
                  st_mid.row   = '0;
                  st_mid.col   = '0;
                  st_mid.grp   = '0;
                  st_mid.carry = '0;
               end
            end else begin
               st_mid.scale[{st_ff.scale_pos, 3'b000} +: 8] = b;
               st_mid.scale_pos = st_ff.scale_pos + 2'd1;
            end
         end
         PH_PAYLOAD: begin
            st_mid.pbytes = st_ff.pbytes + 32'd1;
            bundle.val_a  = take_a;
            bundle.val_b  = take_b;
            bundle.q_a    = q_a;
            bundle.q_b    = q_b;
            bundle.row    = st_ff.row[15:0];
            bundle.col_a  = col_a[15:0];
            bundle.col_b  = col_b[15:0];
            st_mid.seen   = st_ff.seen + {32'b0, take_a} + {32'b0, take_b};
            if (fold_b) begin
               st_mid.csum = csum_two;
            end else if (fold_a) begin
               st_mid.csum = csum_one;
            end
            if (in_stats && take_a) begin
               if (v_a < min_t) min_t = v_a;
               if (v_a > max_t) max_t = v_a;
            end
            if (in_stats && take_b) begin
               if (v_b < min_t) min_t = v_b;
               if (v_b > max_t) max_t = v_b;
            end
            st_mid.smin = min_t;
            st_mid.smax = max_t;
            case (st_ff.grp)
               2'd0: begin
                  st_mid.carry = {2'b0, b[7:6]};
                  st_mid.grp   = 2'd1;
               end
               2'd1: begin
                  st_mid.carry = b[7:4];
                  st_mid.grp   = 2'd2;
               end
               default: begin
                  st_mid.carry = '0;
                  st_mid.grp   = 2'd0;
                  st_mid.col   = col4;
                  if (row_wrap) begin
                     st_mid.col = '0;
                     st_mid.row = row_inc;
                  end
               end
            endcase
         end
         PH_SURPLUS: begin
            if (st_ff.surplus != '1) begin
               st_mid.surplus = st_ff.surplus + 32'd1;
            end
         end
         default: st_mid = st_ff;
      endcase

      if (fin) begin
         have              = $signed(st_mid.smin) <= $signed(st_mid.smax);
         bundle.summary    = 1'b1;
         bundle.checksum   = st_mid.csum;
         bundle.have       = have;
         bundle.min_q      = have ? st_mid.smin[5:0] : 6'd0;
         bundle.max_q      = have ? st_mid.smax[5:0] : 6'd0;
         bundle.missing_en = (phase_mid == PH_SCALES) || (phase_mid == PH_PAYLOAD);
         bundle.rows       = st_mid.rows[16:0];
         bundle.cols       = st_mid.cols[16:0];
         bundle.pbytes     = st_mid.pbytes;
         bundle.surplus    = st_mid.surplus;
         case (phase_mid)
            PH_HEADER:  bundle.status = ST_SHORT_HEADER;
            PH_SCALES:  bundle.status = ST_SHORT_SCALES;
            PH_PAYLOAD: bundle.status = ST_SHORT_PAYLOAD;
            PH_SURPLUS: bundle.status = ST_OK;
            default:    bundle.status = st_mid.status;
         endcase
      end

      if (!item_take) begin
         st_in = st_ff;
      end else if (fin) begin
         st_in = STATE_RST;
      end else begin
         st_in = st_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         st_ff    <= STATE_RST;
      end else begin
         phase_ff <= phase_in;
         st_ff    <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovr_rows_ff   <= '0;
         ovr_cols_ff   <= '0;
         csum_lim_ff   <= CSUM_LIMIT_RST;
         stats_rows_ff <= STATS_ROWS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OVR_ROWS:   ovr_rows_ff   <= csr_wdata[16:0];
            CSR_OVR_COLS:   ovr_cols_ff   <= csr_wdata[16:0];
            CSR_CSUM_LIMIT: csum_lim_ff   <= csr_wdata;
            CSR_STATS_ROWS: stats_rows_ff <= csr_wdata[16:0];
            default:        ovr_rows_ff   <= ovr_rows_ff;
         endcase
      end
   end

endmodule

FILE: sv/isp_emit.sv
// Result sequencer: holds one bundle and issues its results one transfer at a time.
// Depends on isp_pkg; computes the missing-byte count in a short pipeline.
module isp_emit
   import isp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  isp_bundle_type    bundle,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_kind,
   output logic signed [5:0] rsp_q_value,
   output logic [63:0]       rsp_word,
   output logic [15:0]       rsp_row_index,
   output logic [15:0]       rsp_col_index,
   output logic              rsp_last
);

   localparam int NUM_SLOTS = 9;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);

   localparam logic [SLOT_W-1:0] SLOT_VAL_A    = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] SLOT_VAL_B    = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_SCALE    = SLOT_W'(2);
   localparam logic [SLOT_W-1:0] SLOT_STATUS   = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] SLOT_CHECKSUM = SLOT_W'(4);
   localparam logic [SLOT_W-1:0] SLOT_MIN      = SLOT_W'(5);
   localparam logic [SLOT_W-1:0] SLOT_MAX      = SLOT_W'(6);
   localparam logic [SLOT_W-1:0] SLOT_MISSING  = SLOT_W'(7);
   localparam logic [SLOT_W-1:0] SLOT_EXTRA    = SLOT_W'(8);

   logic [NUM_SLOTS-1:0] mask_ff, mask_in, mask_left, low;
   isp_bundle_type       bnd_ff;
   logic [SLOT_W-1:0]    slot;
   logic                 fire;

   logic [17:0] cols_p3;
   logic [15:0] grp_cnt;
   logic [15:0] bpr_ff, bpr_in;
   logic [32:0] prod_full;
   logic [31:0] prod_ff;
   logic [31:0] missing_ff, missing_in;

   assign rsp_valid = |mask_ff;
   assign fire      = rsp_valid && rsp_ready;
   assign low       = mask_ff & (~mask_ff + NUM_SLOTS'(1));
   assign mask_left = fire ? (mask_ff & ~low) : mask_ff;
   assign can_load  = (mask_left == '0);
   assign mask_in   = load ? {{6{bundle.summary}}, bundle.scale, bundle.val_b, bundle.val_a}
                           : mask_left;

   always_comb begin
      slot = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) slot = SLOT_W'(i);
      end
   end

   // missing bytes: rows * bytes_per_row - bytes seen, settled before its slot comes up
   assign cols_p3    = {1'b0, bnd_ff.cols} + 18'd3;
   assign grp_cnt    = cols_p3[17:2];
   assign bpr_in     = grp_cnt + {grp_cnt[14:0], 1'b0};
   assign prod_full  = {16'b0, bnd_ff.rows} * {17'b0, bpr_ff};
   assign missing_in = bnd_ff.missing_en ? (prod_ff - bnd_ff.pbytes) : 32'd0;

   always_comb begin
      rsp_kind      = KIND_VALUE;
      rsp_q_value   = '0;
      rsp_word      = '0;
      rsp_row_index = '0;
      rsp_col_index = '0;
      rsp_last      = 1'b0;
      case (slot)
         SLOT_VAL_A: begin
            rsp_q_value   = $signed(bnd_ff.q_a);
            rsp_row_index = bnd_ff.row;
            rsp_col_index = bnd_ff.col_a;
         end
         SLOT_VAL_B: begin
            rsp_q_value   = $signed(bnd_ff.q_b);
            rsp_row_index = bnd_ff.row;
            rsp_col_index = bnd_ff.col_b;
         end
         SLOT_SCALE: begin
            rsp_kind      = KIND_SCALE;
            rsp_word      = {32'b0, bnd_ff.scale_word};
            rsp_row_index = bnd_ff.row;
         end
         SLOT_STATUS: begin
            rsp_kind = KIND_STATUS;
            rsp_word = {61'b0, bnd_ff.status};
         end
         SLOT_CHECKSUM: begin
            rsp_kind = KIND_CHECKSUM;
            rsp_word = bnd_ff.checksum;
         end
         SLOT_MIN: begin
            rsp_kind    = KIND_MIN;
            rsp_q_value = $signed(bnd_ff.min_q);
            rsp_word    = {63'b0, bnd_ff.have};
         end
         SLOT_MAX: begin
            rsp_kind    = KIND_MAX;
            rsp_q_value = $signed(bnd_ff.max_q);
            rsp_word    = {63'b0, bnd_ff.have};
         end
         SLOT_MISSING: begin
            rsp_kind = KIND_MISSING;
            rsp_word = {32'b0, missing_ff};
         end
         SLOT_EXTRA: begin
            rsp_kind = KIND_EXTRA;
            rsp_word = {32'b0, bnd_ff.surplus};
            rsp_last = 1'b1;
         end
         default: rsp_kind = KIND_VALUE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bnd_ff <= bundle;
      end
      bpr_ff     <= bpr_in;
      prod_ff    <= prod_full[31:0];
      missing_ff <= missing_in;
   end

endmodule

FILE: sv/int6_sidecar_stream_parser_unit.sv
// Path: a byte is registered in the input skid stage, then in the result sequencer.
// Throughput: one byte per cycle while each byte yields at most one result and the
// receiver does not stall; a byte with more results holds the input until its last
// is taken, set by the single result port (the final byte adds 6 summary results).
// Reset: synchronous, active high; clears parser state, queued results and the
// configuration registers to their defaults.
module int6_sidecar_stream_parser_unit
   import isp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_final_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_kind,
   output logic signed [5:0] rsp_q_value,
   output logic [63:0]       rsp_word,
   output logic [15:0]       rsp_row_index,
   output logic [15:0]       rsp_col_index,
   output logic              rsp_last,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   isp_in_type     req_item, item;
   logic           item_valid, item_take, can_load;
   isp_bundle_type bundle;

   assign req_item.data_byte  = req_data_byte;
   assign req_item.final_byte = req_final_byte;
   assign item_take           = item_valid && can_load;

   isp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   isp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item_take (item_take),
      .item      (item),
      .bundle    (bundle)
   );

   isp_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (item_take),
      .bundle        (bundle),
      .can_load      (can_load),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_q_value   (rsp_q_value),
      .rsp_word      (rsp_word),
      .rsp_row_index (rsp_row_index),
      .rsp_col_index (rsp_col_index),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: sv/isp_checker.sv
// Port-level checker for the six-bit stream parser, bound to the top level.
// Depends on isp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module isp_checker
   import isp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [63:0] rsp_word,
   input logic        rsp_last
);

   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_word);
   endproperty

   property p_last_is_extra;
      rsp_valid && rsp_last |-> rsp_kind == KIND_EXTRA;
   endproperty

   property p_status_then_csum;
      rsp_valid && rsp_ready && rsp_kind == KIND_STATUS |=> rsp_valid
         && rsp_kind == KIND_CHECKSUM;
   endproperty

   property p_value_clean;
      rsp_valid && rsp_kind == KIND_VALUE |-> rsp_word == 64'd0 && !rsp_last;
   endproperty

   property p_ready_after_reset;
      reset |=> req_ready;
   endproperty

   `ISP_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "result changed while stalled")
   `ISP_ASSERT(a_last_is_extra, clock, reset, p_last_is_extra, "last on a non-extra result")
   `ISP_ASSERT(a_status_then_csum, clock, reset, p_status_then_csum, "no checksum after status")
   `ISP_ASSERT(a_value_clean, clock, reset, p_value_clean, "value carries word or last")
   `ISP_ASSERT_ALWAYS(a_ready_after_reset, clock, p_ready_after_reset, "not ready after reset")

endmodule

bind int6_sidecar_stream_parser_unit isp_checker u_isp_checker (.*);

FILE: sim/tb_int6_sidecar_stream_parser_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for int6_sidecar_stream_parser_unit: streams sidecar files
// byte by byte, predicts each result in place and checks every result transfer.
// Depends on isp_pkg and the parser unit only.
module tb_int6_sidecar_stream_parser_unit;
   import isp_pkg::*;

   localparam logic [31:0] FILE_TAG = 32'h3654_5250;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } file_byte_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  q;
      logic [63:0] word;
      logic [15:0] row;
      logic [15:0] col;
      logic        last;
   } parse_result_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_data_byte = '0;
   logic              req_final_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [2:0]        rsp_kind;
   logic signed [5:0] rsp_q_value;
   logic [63:0]       rsp_word;
   logic [15:0]       rsp_row_index;
   logic [15:0]       rsp_col_index;
   logic              rsp_last;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [31:0]       csr_wdata = '0;

   file_byte_type    file_bytes[$];
   parse_result_type pending_results[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned fail_count = 0;
   int unsigned bytes_accepted = 0;
   int unsigned results_seen = 0;
   int unsigned files_done = 0;

   // register values as written by the stimulus
   logic [16:0] stim_ovr_rows = '0;
   logic [16:0] stim_ovr_cols = '0;

   // parser state and register copy of the predictor
   logic [16:0] cfg_ovr_rows;
   logic [16:0] cfg_ovr_cols;
   logic [31:0] cfg_csum_limit;
   logic [16:0] cfg_stats_rows;
   phase_type   prs_phase;
   int unsigned hdr_cnt;
   logic [31:0] rows_eff;
   logic [31:0] cols_eff;
   logic [31:0] scale_acc;
   int unsigned scale_pos;
   logic [31:0] row_ctr;
   logic [31:0] col_ctr;
   int unsigned grp_pos;
   logic [3:0]  carry;
   logic [63:0] csum;
   logic [63:0] elem_cnt;
   logic [63:0] pay_cnt;
   int          smin;
   int          smax;
   logic [31:0] extra_cnt;
   logic [2:0]  err_code;

   int6_sidecar_stream_parser_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_q_value    (rsp_q_value),
      .rsp_word       (rsp_word),
      .rsp_row_index  (rsp_row_index),
      .rsp_col_index  (rsp_col_index),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_parser();
      prs_phase = PH_HEADER;
      hdr_cnt   = 0;
      rows_eff  = '0;
      cols_eff  = '0;
      scale_acc = '0;
      scale_pos = 0;
      row_ctr   = '0;
      col_ctr   = '0;
      grp_pos   = 0;
      carry     = '0;
      csum      = '0;
      elem_cnt  = '0;
      pay_cnt   = '0;
      smin      = 127;
      smax      = -127;
      extra_cnt = '0;
      err_code  = ST_OK;
   endfunction

   function automatic void load_reg(input logic [1:0] idx, input logic [31:0] val);
      case (idx)
         CSR_OVR_ROWS:   cfg_ovr_rows   = val[16:0];
         CSR_OVR_COLS:   cfg_ovr_cols   = val[16:0];
         CSR_CSUM_LIMIT: cfg_csum_limit = val;
         default:        cfg_stats_rows = val[16:0];
      endcase
   endfunction

   function automatic void expect_result(input logic [2:0] kind, input logic [5:0] q,
                                         input logic [63:0] word, input logic [15:0] row,
                                         input logic [15:0] col, input logic last);
      pending_results.push_back({kind, q, word, row, col, last});
   endfunction

   function automatic void close_header();
      if (cfg_ovr_rows != 0) rows_eff = 32'(cfg_ovr_rows);
      if (cfg_ovr_cols != 0) cols_eff = 32'(cfg_ovr_cols);
      if (rows_eff > MAX_ROWS || cols_eff > MAX_COLS) begin
         err_code  = ST_OVERSIZE;
         prs_phase = PH_ERROR;
      end else if (rows_eff == 0) begin
         prs_phase = PH_SURPLUS;
      end else begin
         prs_phase = PH_SCALES;
         row_ctr   = '0;
         scale_pos = 0;
         scale_acc = '0;
      end
   endfunction

   function automatic void open_payload();
      row_ctr = '0;
      col_ctr = '0;
      grp_pos = 0;
      carry   = '0;
      if (cols_eff == 0) prs_phase = PH_SURPLUS;
      else prs_phase = PH_PAYLOAD;
   endfunction

   function automatic void take_code(input logic [5:0] code, input logic [31:0] col);
      int v;
      if (col < cols_eff) begin
         v = int'(code) - 32;
         if (elem_cnt < {32'b0, cfg_csum_limit}) csum = csum * 31 + code;
         elem_cnt++;
         if (row_ctr < cfg_stats_rows) begin
            if (v < smin) smin = v;
            if (v > smax) smax = v;
         end
         expect_result(KIND_VALUE, code ^ SIGN_FLIP, '0, row_ctr[15:0], col[15:0], 1'b0);
      end
   endfunction

   function automatic logic [63:0] payload_len();
      return 64'(rows_eff) * (((64'(cols_eff) + 3) / 4) * 3);
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic fin);
      int unsigned h;
      logic [2:0]  st;
      logic [63:0] missing;
      logic        have;
      case (prs_phase)
         PH_HEADER: begin
            h = hdr_cnt;
            if (h < 4 && b != FILE_TAG[8*h +: 8]) begin
               err_code  = ST_BAD_MAGIC;
               prs_phase = PH_ERROR;
            end else begin
               if (h >= 8 && h < 12) rows_eff[8*(h-8) +: 8] = b;
               else if (h >= 12 && h < 16) cols_eff[8*(h-12) +: 8] = b;
               hdr_cnt = h + 1;
               if (hdr_cnt >= HEADER_BYTES) close_header();
            end
         end
         PH_SCALES: begin
            scale_acc[8*scale_pos +: 8] = b;
            scale_pos = (scale_pos + 1) % 4;
            if (scale_pos == 0) begin
               expect_result(KIND_SCALE, '0, {32'b0, scale_acc}, row_ctr[15:0], '0, 1'b0);
               scale_acc = '0;
               row_ctr++;
               if (row_ctr >= rows_eff) open_payload();
            end
         end
         PH_PAYLOAD: begin
            pay_cnt++;
            case (grp_pos)
               0: begin
                  take_code(b[5:0], col_ctr);
                  carry   = {2'b00, b[7:6]};
                  grp_pos = 1;
               end
               1: begin
                  take_code({b[3:0], carry[1:0]}, col_ctr + 1);
                  carry   = b[7:4];
                  grp_pos = 2;
               end
               default: begin
                  take_code({b[1:0], carry}, col_ctr + 2);
                  take_code(b[7:2], col_ctr + 3);
                  grp_pos = 0;
                  carry   = '0;
                  col_ctr += 4;
                  if (col_ctr >= cols_eff) begin
                     col_ctr = '0;
                     row_ctr++;
                     if (row_ctr >= rows_eff) prs_phase = PH_SURPLUS;
                  end
               end
            endcase
         end
         PH_SURPLUS: begin
            if (extra_cnt != 32'hFFFF_FFFF) extra_cnt++;
         end
         default: ;
      endcase

      if (fin) begin
         have    = (smin <= smax);
         missing = '0;
         case (prs_phase)
            PH_HEADER:  st = ST_SHORT_HEADER;
            PH_SCALES:  st = ST_SHORT_SCALES;
            PH_PAYLOAD: st = ST_SHORT_PAYLOAD;
            PH_SURPLUS: st = ST_OK;
            default:    st = err_code;
         endcase
         if (prs_phase == PH_SCALES || prs_phase == PH_PAYLOAD)
            missing = payload_len() - pay_cnt;
         expect_result(KIND_STATUS, '0, {61'b0, st}, '0, '0, 1'b0);
         expect_result(KIND_CHECKSUM, '0, csum, '0, '0, 1'b0);
         expect_result(KIND_MIN, have ? smin[5:0] : 6'd0, {63'b0, have}, '0, '0, 1'b0);
         expect_result(KIND_MAX, have ? smax[5:0] : 6'd0, {63'b0, have}, '0, '0, 1'b0);
         expect_result(KIND_MISSING, '0, missing, '0, '0, 1'b0);
         expect_result(KIND_EXTRA, '0, {32'b0, extra_cnt}, '0, '0, 1'b1);
         clear_parser();
         files_done++;
      end
   endfunction

   // ------------------------------------------------------------ driver, monitor

   always @(posedge clock) begin : drive_proc
      file_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (file_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            nxt = file_bytes.pop_front();
            req_valid      <= 1'b1;
            req_data_byte  <= nxt.data;
            req_final_byte <= nxt.fin;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_proc
      parse_result_type exp_r;
      if (reset) begin
         rsp_ready      <= 1'b0;
         cfg_ovr_rows   = '0;
         cfg_ovr_cols   = '0;
         cfg_csum_limit = CSUM_LIMIT_RST;
         cfg_stats_rows = STATS_ROWS_RST;
         clear_parser();
      end else begin
         if (csr_we) load_reg(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            parse_byte(req_data_byte, req_final_byte);
            bytes_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $display("%0t: result with none expected, actual kind %0d word %h",
                        $time, rsp_kind, rsp_word);
               fail_count++;
            end else begin
               exp_r = pending_results.pop_front();
               check_field("kind", exp_r.kind, rsp_kind);
               check_field("q_value", exp_r.q, $unsigned(rsp_q_value));
               check_field("word", exp_r.word, rsp_word);
               check_field("row_index", exp_r.row, rsp_row_index);
               check_field("col_index", exp_r.col, rsp_col_index);
               check_field("last", exp_r.last, rsp_last);
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------ stimulus

   function automatic void push_byte(input logic [7:0] b);
      file_bytes.push_back({b, 1'b0});
   endfunction

   function automatic void mark_file_end();
      file_bytes[file_bytes.size() - 1].fin = 1'b1;
   endfunction

   function automatic void push_header(input logic [31:0] rows_h, input logic [31:0] cols_h,
                                       input int n);
      logic [127:0] hdr;
      hdr = {cols_h, rows_h, 32'($urandom), FILE_TAG};
      for (int i = 0; i < n; i++) push_byte(hdr[8*i +: 8]);
   endfunction

   function automatic void queue_random_file();
      int unsigned sel;
      int unsigned pos;
      int unsigned n_body;
      logic [31:0] rows_h;
      logic [31:0] cols_h;
      logic [31:0] r_eff;
      logic [31:0] c_eff;
      logic [63:0] full;
      sel    = $urandom_range(99, 0);
      rows_h = $urandom_range(3, 1);
      cols_h = $urandom_range(9, 1);
      if (sel < 8) begin
         pos = $urandom_range(3, 0);
         push_header(rows_h, cols_h, pos);
         push_byte(FILE_TAG[8*pos +: 8] ^ 8'($urandom_range(255, 1)));
         n_body = $urandom_range(3, 0);
      end else if (sel < 14) begin
         push_header(rows_h, cols_h, $urandom_range(15, 1));
         n_body = 0;
      end else begin
         if (sel < 20) begin
            if ($urandom_range(1, 0)) rows_h = $urandom_range(32'hFFFF_FFFF, MAX_ROWS + 1);
            else cols_h = $urandom_range(32'hFFFF_FFFF, MAX_COLS + 1);
         end else if (sel < 28) begin
            if ($urandom_range(1, 0)) rows_h = '0;
            else cols_h = '0;
         end
         push_header(rows_h, cols_h, HEADER_BYTES);
         r_eff = (stim_ovr_rows != 0) ? 32'(stim_ovr_rows) : rows_h;
         c_eff = (stim_ovr_cols != 0) ? 32'(stim_ovr_cols) : cols_h;
         if (r_eff > MAX_ROWS || c_eff > MAX_COLS) begin
            n_body = $urandom_range(3, 0);
         end else begin
            full = 64'(r_eff) * 4 + 64'(r_eff) * (((64'(c_eff) + 3) / 4) * 3);
            if (full > 80) n_body = $urandom_range(24, 0);
            else if (sel >= 28 && sel < 40 && full > 0)
               n_body = $urandom_range(32'(full - 1), 0);
            else n_body = 32'(full) + $urandom_range(2, 0);
         end
      end
      for (int i = 0; i < n_body; i++) push_byte(8'($urandom));
      mark_file_end();
   endfunction

   function automatic void queue_random_bytes(input int unsigned target);
      while (file_bytes.size() < target) queue_random_file();
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (file_bytes.size() != 0 || req_valid || pending_results.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_OVR_ROWS: stim_ovr_rows = val[16:0];
         CSR_OVR_COLS: stim_ovr_cols = val[16:0];
         default: ;
      endcase
   endtask

   task automatic write_all_regs(input logic [31:0] ovr_rows, input logic [31:0] ovr_cols,
                                 input logic [31:0] csum_limit, input logic [31:0] stats);
      write_reg(CSR_OVR_ROWS, ovr_rows);
      write_reg(CSR_OVR_COLS, ovr_cols);
      write_reg(CSR_CSUM_LIMIT, csum_limit);
      write_reg(CSR_STATS_ROWS, stats);
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // bad magic on the first byte, a header cut short, then one full file with
      // extreme codes, dropped columns and trailing bytes
      push_byte(8'h00);
      mark_file_end();
      push_header(32'd1, 32'd1, 2);
      mark_file_end();
      push_header(32'd1, 32'd5, HEADER_BYTES);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h80);
      push_byte(8'h7F);
      repeat (3) push_byte(8'h00);
      repeat (3) push_byte(8'hFF);
      push_byte(8'hA5);
      push_byte(8'h5A);
      mark_file_end();
      wait_drained();

      write_all_regs(32'd0, 32'd3, 32'd0, 32'd0);
      send_idle_pct = 54;
      queue_random_bytes(15);
      wait_drained();

      write_all_regs(32'd2, 32'd0, 32'd5, 32'd1);
      send_idle_pct  = 0;
      recv_stall_pct = 54;
      queue_random_bytes(15);
      wait_drained();

      write_all_regs(32'd65536, 32'd65536, 32'hFFFF_FFFF, 32'd65536);
      send_idle_pct  = 14;
      recv_stall_pct = 14;
      queue_random_file();
      wait_drained();

      $display("run covered %0d files, %0d bytes and %0d results", files_done,
               bytes_accepted, results_seen);
      $display("over four register settings and four mixes of sender and receiver idling");
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("status: fail");
      $finish;
   end

endmodule
